// ===== sv/clcf_pkg.sv =====
// Package with types, codes and constants for the camera link control block.
`timescale 1ns / 1ps
`default_nettype none

package clcf_pkg;

  localparam int TICK_COUNT_BITS_DEF = 16;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] POWER_PULSE_RESET = 16'd333;
  localparam logic [CFG_W-1:0] CMD_TIMEOUT_RESET = 16'd667;

  localparam logic [CFG_IDX_W-1:0] REG_POWER_PULSE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_TIMEOUT = 1'd1;

  localparam logic [7:0] FRAME_LEN_BYTE = 8'h03;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SEND  = 2'd1;
  localparam logic [1:0] CMD_POWER = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] RES_UNKNOWN = 2'd0;
  localparam logic [1:0] RES_SUCCESS = 2'd1;
  localparam logic [1:0] RES_TIMEOUT = 2'd2;

  localparam logic [1:0] PWR_OFF  = 2'd0;
  localparam logic [1:0] PWR_ON   = 2'd1;
  localparam logic [1:0] PWR_WAIT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_PWR_REQ  = 3'd1,
    ST_PWR_WAIT = 3'd2,
    ST_CMD_WAIT = 3'd3,
    ST_RESPONSE = 3'd4
  } state_e;

  typedef struct packed {
    logic [CFG_W-1:0] power_pulse_ticks;
    logic [CFG_W-1:0] command_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] name_byte_one;
    logic [7:0] name_byte_two;
    logic [7:0] argument_byte;
    logic       addressed;
    logic       as_transmitter;
    logic       bus_busy;
    logic       voltage_present;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       ready_res;
    logic [1:0] power_status;
    logic [1:0] last_result;
    logic       power_pin_low;
    logic       interrupt_asserted;
    logic       frame_valid;
    logic [7:0] frame_length;
    logic [7:0] frame_name_one;
    logic [7:0] frame_name_two;
    logic [7:0] frame_argument;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/clcf_if.sv =====
// Valid/ready channel interfaces for the input and result transactions.
`timescale 1ns / 1ps
`default_nettype none

interface clcf_in_if import clcf_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface clcf_out_if import clcf_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/clcf_cfg_regs.sv =====
// Configuration registers for the power pulse and command timeout limits.
`timescale 1ns / 1ps
`default_nettype none

module clcf_cfg_regs import clcf_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_pulse_ticks     <= POWER_PULSE_RESET;
      cfg_q.command_timeout_ticks <= CMD_TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POWER_PULSE: cfg_q.power_pulse_ticks <= cfg_data_i;
        REG_CMD_TIMEOUT: cfg_q.command_timeout_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/clcf_ctrl.sv =====
// Control state machine, tick counters and frame latch; forms one result per transaction.
`timescale 1ns / 1ps
`default_nettype none

module clcf_ctrl import clcf_pkg::*; #(
  parameter int TickBits = TICK_COUNT_BITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     accept_i,
  input  wire in_item_t item_i,
  output out_item_t     res_o
);

  localparam int LW = (TickBits > CFG_W) ? TickBits : CFG_W;

  state_e               state_q, state_d;
  logic [TickBits-1:0]  pwr_cnt_q, pwr_cnt_d;
  logic [TickBits-1:0]  wait_cnt_q, wait_cnt_d;
  logic [1:0]           result_q, result_d;
  logic                 pin_q, pin_d;
  logic                 irq_q, irq_d;
  logic [7:0]           latch_q [3];
  logic                 latch_en;
  logic                 sent;
  logic                 acc;

  logic [LW-1:0] cnt_max_w;
  logic [LW-1:0] pwr_lim_w, pwr_lim;
  logic [LW-1:0] wait_lim_w, wait_lim;
  logic          pwr_past, wait_past;
  logic [TickBits-1:0] pwr_cnt_inc, wait_cnt_inc;

  // Limits at or above the counter maximum are clamped to maximum minus one.
  assign cnt_max_w  = LW'({TickBits{1'b1}});
  assign pwr_lim_w  = LW'(cfg_i.power_pulse_ticks);
  assign wait_lim_w = LW'(cfg_i.command_timeout_ticks);
  assign pwr_lim    = (pwr_lim_w >= cnt_max_w) ? cnt_max_w - LW'(1) : pwr_lim_w;
  assign wait_lim   = (wait_lim_w >= cnt_max_w) ? cnt_max_w - LW'(1) : wait_lim_w;
  assign pwr_past   = LW'(pwr_cnt_q) > pwr_lim;
  assign wait_past  = LW'(wait_cnt_q) > wait_lim;
  assign pwr_cnt_inc  = (pwr_cnt_q == {TickBits{1'b1}}) ? pwr_cnt_q
                                                         : pwr_cnt_q + TickBits'(1);
  assign wait_cnt_inc = (wait_cnt_q == {TickBits{1'b1}}) ? wait_cnt_q
                                                          : wait_cnt_q + TickBits'(1);

  always_comb begin
    state_d    = state_q;
    pwr_cnt_d  = pwr_cnt_q;
    wait_cnt_d = wait_cnt_q;
    result_d   = result_q;
    pin_d      = pin_q;
    irq_d      = irq_q;
    latch_en   = 1'b0;
    sent       = 1'b0;
    acc        = 1'b0;

    unique case (item_i.command)
      CMD_SEND: begin
        if (state_q == ST_IDLE) begin
          latch_en   = 1'b1;
          irq_d      = 1'b1;
          wait_cnt_d = '0;
          state_d    = ST_CMD_WAIT;
          acc        = 1'b1;
        end
      end
      CMD_POWER: begin
        if (state_q == ST_IDLE) begin
          state_d = ST_PWR_REQ;
          acc     = 1'b1;
        end
      end
      CMD_TICK: begin
        unique case (state_q)
          ST_PWR_REQ: begin
            pin_d     = 1'b1;
            pwr_cnt_d = '0;
            state_d   = ST_PWR_WAIT;
          end
          ST_PWR_WAIT: begin
            pwr_cnt_d = pwr_cnt_inc;
            if (pwr_past) begin
              pin_d   = 1'b0;
              state_d = ST_IDLE;
            end
          end
          ST_CMD_WAIT: begin
            wait_cnt_d = wait_cnt_inc;
            if (wait_past) begin
              wait_cnt_d = '0;
              irq_d      = 1'b0;
              result_d   = RES_TIMEOUT;
              state_d    = ST_IDLE;
            end
            if (item_i.addressed && item_i.as_transmitter) begin
              irq_d   = 1'b0;
              sent    = 1'b1;
              state_d = ST_RESPONSE;
            end
          end
          ST_RESPONSE: begin
            result_d = RES_SUCCESS;
            state_d  = ST_IDLE;
          end
          default: ;
        endcase
      end
      CMD_QUERY: ;
      default: ;
    endcase

    res_o.accepted           = acc;
    res_o.ready_res          = (state_d == ST_IDLE) && !item_i.bus_busy;
    if (state_d == ST_PWR_REQ || state_d == ST_PWR_WAIT) begin
      res_o.power_status     = PWR_WAIT;
    end else begin
      res_o.power_status     = item_i.voltage_present ? PWR_ON : PWR_OFF;
    end
    res_o.last_result        = result_d;
    res_o.power_pin_low      = pin_d;
    res_o.interrupt_asserted = irq_d;
    res_o.frame_valid        = sent;
    res_o.frame_length       = sent ? FRAME_LEN_BYTE : 8'd0;
    res_o.frame_name_one     = sent ? latch_q[0] : 8'd0;
    res_o.frame_name_two     = sent ? latch_q[1] : 8'd0;
    res_o.frame_argument     = sent ? latch_q[2] : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pwr_cnt_q  <= '0;
      wait_cnt_q <= '0;
      result_q   <= RES_UNKNOWN;
      pin_q      <= 1'b0;
      irq_q      <= 1'b0;
    end else if (accept_i) begin
      state_q    <= state_d;
      pwr_cnt_q  <= pwr_cnt_d;
      wait_cnt_q <= wait_cnt_d;
      result_q   <= result_d;
      pin_q      <= pin_d;
      irq_q      <= irq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && latch_en) begin
      latch_q[0] <= item_i.name_byte_one;
      latch_q[1] <= item_i.name_byte_two;
      latch_q[2] <= item_i.argument_byte;
    end
  end

endmodule

`default_nettype wire

// ===== sv/clcf_out_reg.sv =====
// Result register that holds one finished result until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module clcf_out_reg import clcf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire out_item_t res_i,
  output logic           can_load_o,
  clcf_out_if.source     out_if
);

  logic      valid_q;
  out_item_t data_q;

  assign can_load_o = !valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && can_load_o) begin
      data_q <= res_i;
    end
  end

  assign out_if.valid = valid_q;
  assign out_if.data  = data_q;

endmodule

`default_nettype wire

// ===== sv/camera_link_control_fsm.sv =====
// Top level of the camera accessory link controller.
// Latency: a result is registered in the result register in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while input ready is high; input ready is high whenever the result register
// is empty or is being read in the same cycle.
// Reset: asynchronous, active low; the machine returns to idle, counters and result code clear,
// configuration registers take their default limits, and the frame latch is not reset.
`timescale 1ns / 1ps
`default_nettype none

module camera_link_control_fsm import clcf_pkg::*; #(
  parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  clcf_in_if.sink                   in_if,
  clcf_out_if.source                out_if
);

  cfg_t      cfg;
  out_item_t res;
  logic      can_load;
  logic      accept;

  assign in_if.ready = can_load;
  assign accept      = in_if.valid && can_load;

  clcf_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  clcf_ctrl #(
    .TickBits (TICK_COUNT_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .item_i   (in_if.data),
    .res_o    (res)
  );

  clcf_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_if.valid),
    .res_i      (res),
    .can_load_o (can_load),
    .out_if     (out_if)
  );

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_if.valid)
    else $error("accepted transaction did not produce a result");

  a_accepted_only_requests: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res.accepted) |->
      (in_if.data.command == CMD_SEND || in_if.data.command == CMD_POWER))
    else $error("accepted flag set for a tick or a query");

  a_frame_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.data.frame_valid) |-> out_if.data.frame_length == FRAME_LEN_BYTE)
    else $error("frame sent with wrong length byte");

  a_power_wait_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.data.power_status == PWR_WAIT) |-> !out_if.data.ready_res)
    else $error("ready reported while power request pending");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the camera link controller: directed table and random traffic vs. a predictor.
`timescale 1ns / 1ps

module tb;
  import clcf_pkg::*;

  typedef struct {
    in_item_t  stim;
    int        reps;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  clcf_in_if  link_in ();
  clcf_out_if link_out ();

  camera_link_control_fsm u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (link_in),
    .out_if     (link_out)
  );

  state_e     link_st = ST_IDLE;
  logic [15:0] pulse_ticks_seen = '0;
  logic [15:0] wait_ticks_seen = '0;
  logic [7:0]  frame_bytes [0:2] = '{8'h00, 8'h00, 8'h00};
  logic [1:0]  outcome = RES_UNKNOWN;
  logic        pin_held_low = 1'b0;
  logic        irq_raised = 1'b0;
  logic [15:0] cfg_pulse_limit = POWER_PULSE_RESET;
  logic [15:0] cfg_timeout_limit = CMD_TIMEOUT_RESET;

  out_item_t   expected_status_q [$];
  dir_row_t    dir_rows [$];
  bit          no_gaps = 1'b0;
  int unsigned mismatch_count = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [15:0] clamp_limit(logic [15:0] lim);
    return (lim >= 16'hFFFF) ? 16'hFFFE : lim;
  endfunction

  function automatic out_item_t predict_link_response(in_item_t it);
    out_item_t r;
    logic      sent;
    logic      past;
    r = '0;
    sent = 1'b0;
    case (it.command)
      CMD_SEND: begin
        if (link_st == ST_IDLE) begin
          frame_bytes[0] = it.name_byte_one;
          frame_bytes[1] = it.name_byte_two;
          frame_bytes[2] = it.argument_byte;
          irq_raised = 1'b1;
          wait_ticks_seen = '0;
          link_st = ST_CMD_WAIT;
          r.accepted = 1'b1;
        end
      end
      CMD_POWER: begin
        if (link_st == ST_IDLE) begin
          link_st = ST_PWR_REQ;
          r.accepted = 1'b1;
        end
      end
      CMD_TICK: begin
        case (link_st)
          ST_PWR_REQ: begin
            pin_held_low = 1'b1;
            pulse_ticks_seen = '0;
            link_st = ST_PWR_WAIT;
          end
          ST_PWR_WAIT: begin
            past = pulse_ticks_seen > clamp_limit(cfg_pulse_limit);
            if (pulse_ticks_seen != 16'hFFFF) pulse_ticks_seen = pulse_ticks_seen + 16'd1;
            if (past) begin
              pin_held_low = 1'b0;
              link_st = ST_IDLE;
            end
          end
          ST_CMD_WAIT: begin
            past = wait_ticks_seen > clamp_limit(cfg_timeout_limit);
            if (wait_ticks_seen != 16'hFFFF) wait_ticks_seen = wait_ticks_seen + 16'd1;
            if (past) begin
              wait_ticks_seen = '0;
              irq_raised = 1'b0;
              outcome = RES_TIMEOUT;
              link_st = ST_IDLE;
            end
            if (it.addressed && it.as_transmitter) begin
              irq_raised = 1'b0;
              sent = 1'b1;
              link_st = ST_RESPONSE;
            end
          end
          ST_RESPONSE: begin
            outcome = RES_SUCCESS;
            link_st = ST_IDLE;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.ready_res = (link_st == ST_IDLE) && !it.bus_busy;
    if (link_st == ST_PWR_REQ || link_st == ST_PWR_WAIT) r.power_status = PWR_WAIT;
    else r.power_status = it.voltage_present ? PWR_ON : PWR_OFF;
    r.last_result = outcome;
    r.power_pin_low = pin_held_low;
    r.interrupt_asserted = irq_raised;
    if (sent) begin
      r.frame_valid = 1'b1;
      r.frame_length = FRAME_LEN_BYTE;
      r.frame_name_one = frame_bytes[0];
      r.frame_name_two = frame_bytes[1];
      r.frame_argument = frame_bytes[2];
    end
    return r;
  endfunction

  function automatic in_item_t link_req(logic [1:0] cmd, logic [7:0] b1, logic [7:0] b2,
                                        logic [7:0] b3, logic addr, logic tx, logic busy,
                                        logic vp);
    in_item_t r;
    r.command = cmd;
    r.name_byte_one = b1;
    r.name_byte_two = b2;
    r.argument_byte = b3;
    r.addressed = addr;
    r.as_transmitter = tx;
    r.bus_busy = busy;
    r.voltage_present = vp;
    return r;
  endfunction

  function automatic out_item_t status_word(logic acc, logic rdy, logic [1:0] ps,
                                            logic [1:0] lr, logic pin, logic irq, logic fv,
                                            logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
    out_item_t r;
    r.accepted = acc;
    r.ready_res = rdy;
    r.power_status = ps;
    r.last_result = lr;
    r.power_pin_low = pin;
    r.interrupt_asserted = irq;
    r.frame_valid = fv;
    r.frame_length = fv ? FRAME_LEN_BYTE : 8'h00;
    r.frame_name_one = b1;
    r.frame_name_two = b2;
    r.frame_argument = b3;
    return r;
  endfunction

  function automatic in_item_t random_req();
    in_item_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) r.command = CMD_TICK;
    else if (pick < 72) r.command = CMD_SEND;
    else if (pick < 82) r.command = CMD_POWER;
    else r.command = CMD_QUERY;
    r.name_byte_one = 8'($urandom);
    r.name_byte_two = 8'($urandom);
    r.argument_byte = 8'($urandom);
    r.addressed = ($urandom_range(0, 7) == 0);
    r.as_transmitter = 1'($urandom);
    r.bus_busy = 1'($urandom);
    r.voltage_present = 1'($urandom);
    return r;
  endfunction

  task automatic add_row(in_item_t s, int reps, bit typed, out_item_t w);
    dir_row_t row;
    row.stim = s;
    row.reps = reps;
    row.typed = typed;
    row.want = w;
    dir_rows.push_back(row);
  endtask

  task automatic push_request(in_item_t it, bit typed, out_item_t typed_want);
    int unsigned gap;
    out_item_t   want;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      link_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    link_in.valid <= 1'b1;
    link_in.data <= it;
    do @(posedge clk_i); while (!link_in.ready);
    want = predict_link_response(it);
    expected_status_q.push_back(typed ? typed_want : want);
  endtask

  task automatic drain_to_idle();
    in_item_t t;
    while (link_st != ST_IDLE) begin
      t = random_req();
      t.command = CMD_TICK;
      t.addressed = 1'b0;
      push_request(t, 1'b0, '0);
    end
  endtask

  task automatic program_limits(logic [15:0] pulse, logic [15:0] timeout);
    link_in.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_POWER_PULSE;
    cfg_data_i <= pulse;
    @(posedge clk_i);
    cfg_idx_i <= REG_CMD_TIMEOUT;
    cfg_data_i <= timeout;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_pulse_limit = pulse;
    cfg_timeout_limit = timeout;
  endtask

  task automatic compare_status(out_item_t want, out_item_t got);
    string diffs;
    diffs = "";
    if (got.accepted !== want.accepted) diffs = {diffs, " accepted"};
    if (got.ready_res !== want.ready_res) diffs = {diffs, " ready_res"};
    if (got.power_status !== want.power_status) diffs = {diffs, " power_status"};
    if (got.last_result !== want.last_result) diffs = {diffs, " last_result"};
    if (got.power_pin_low !== want.power_pin_low) diffs = {diffs, " power_pin_low"};
    if (got.interrupt_asserted !== want.interrupt_asserted) diffs = {diffs, " interrupt"};
    if (got.frame_valid !== want.frame_valid) diffs = {diffs, " frame_valid"};
    if (got.frame_length !== want.frame_length) diffs = {diffs, " frame_length"};
    if (got.frame_name_one !== want.frame_name_one) diffs = {diffs, " frame_name_one"};
    if (got.frame_name_two !== want.frame_name_two) diffs = {diffs, " frame_name_two"};
    if (got.frame_argument !== want.frame_argument) diffs = {diffs, " frame_argument"};
    if (diffs != "") begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: status mismatch in%s: expected %p, got %p", $realtime, diffs, want, got);
      end
    end
  endtask

  initial begin : result_monitor
    int unsigned gap;
    out_item_t   got;
    link_out.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        link_out.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      link_out.ready <= 1'b1;
      do @(posedge clk_i); while (!(link_out.valid && link_out.ready));
      got = link_out.data;
      if (expected_status_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: unexpected status transaction %p", $realtime, got);
      end else begin
        compare_status(expected_status_q.pop_front(), got);
      end
    end
  end

  initial begin : stimulus
    logic [15:0] pulse_set [0:5];
    logic [15:0] timeout_set [0:5];
    int          n;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_POWER_PULSE;
    cfg_data_i <= '0;
    link_in.valid <= 1'b0;
    link_in.data <= '0;
    pulse_set = '{16'd0, 16'd1, 16'd3, 16'd12, 16'd0, 16'd0};
    timeout_set = '{16'd0, 16'd2, 16'd20, 16'd6, 16'd0, 16'd0};
    for (n = 4; n < 6; n++) begin
      pulse_set[n] = 16'($urandom_range(0, 40));
      timeout_set[n] = 16'($urandom_range(0, 80));
    end

    add_row(link_req(CMD_QUERY, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0), 1, 1,
            status_word(0, 1, PWR_OFF, RES_UNKNOWN, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    add_row(link_req(CMD_QUERY, 8'hFF, 8'hFF, 8'hFF, 1, 1, 1, 1), 1, 1,
            status_word(0, 0, PWR_ON, RES_UNKNOWN, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    add_row(link_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0), 1, 0, '0);
    add_row(link_req(CMD_SEND, 8'hFF, 8'h00, 8'hFF, 0, 0, 0, 0), 1, 1,
            status_word(1, 0, PWR_OFF, RES_UNKNOWN, 0, 1, 0, 8'h00, 8'h00, 8'h00));
    add_row(link_req(CMD_SEND, 8'h12, 8'h34, 8'h56, 0, 0, 0, 1), 1, 1,
            status_word(0, 0, PWR_ON, RES_UNKNOWN, 0, 1, 0, 8'h00, 8'h00, 8'h00));
    add_row(link_req(CMD_POWER, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0), 1, 1,
            status_word(0, 0, PWR_OFF, RES_UNKNOWN, 0, 1, 0, 8'h00, 8'h00, 8'h00));
    add_row(link_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 1, 0, 0, 0), 1, 0, '0);
    add_row(link_req(CMD_QUERY, 8'h00, 8'h00, 8'h00, 1, 1, 0, 0), 1, 0, '0);
    add_row(link_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 1, 1, 0, 0), 1, 1,
            status_word(0, 0, PWR_OFF, RES_UNKNOWN, 0, 0, 1, 8'hFF, 8'h00, 8'hFF));
    add_row(link_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 0, 0, 1, 1), 1, 1,
            status_word(0, 0, PWR_ON, RES_SUCCESS, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    add_row(link_req(CMD_SEND, 8'h00, 8'hFF, 8'h00, 0, 0, 0, 0), 1, 0, '0);
    add_row(link_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 0, 1, 0, 0), 668, 0, '0);
    add_row(link_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 1, 1, 0, 0), 1, 1,
            status_word(0, 0, PWR_OFF, RES_TIMEOUT, 0, 0, 1, 8'h00, 8'hFF, 8'h00));
    add_row(link_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0), 1, 1,
            status_word(0, 1, PWR_OFF, RES_SUCCESS, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    add_row(link_req(CMD_POWER, 8'h00, 8'h00, 8'h00, 0, 0, 1, 1), 1, 1,
            status_word(1, 0, PWR_WAIT, RES_SUCCESS, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    add_row(link_req(CMD_SEND, 8'hAA, 8'h55, 8'hAA, 0, 0, 0, 0), 1, 0, '0);
    add_row(link_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 0, 0, 0, 1), 1, 1,
            status_word(0, 0, PWR_WAIT, RES_SUCCESS, 1, 0, 0, 8'h00, 8'h00, 8'h00));
    add_row(link_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0), 334, 0, '0);
    add_row(link_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0), 1, 1,
            status_word(0, 1, PWR_OFF, RES_SUCCESS, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    add_row(link_req(CMD_TICK, 8'hFF, 8'hFF, 8'hFF, 1, 1, 1, 1), 1, 0, '0);
    add_row(link_req(CMD_POWER, 8'h00, 8'h00, 8'h00, 1, 1, 0, 0), 1, 0, '0);
    add_row(link_req(CMD_QUERY, 8'h00, 8'h00, 8'h00, 0, 0, 0, 1), 1, 0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (dir_rows[i].reps) push_request(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    end
    drain_to_idle();

    for (int p = 0; p < 6; p++) begin
      drain_to_idle();
      program_limits(pulse_set[p], timeout_set[p]);
      for (n = 0; n < 64; n++) begin
        if (n % 32 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        push_request(random_req(), 1'b0, '0);
      end
    end

    link_in.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== camera_link_control_fsm.f =====
sv/clcf_pkg.sv
sv/clcf_if.sv
sv/clcf_cfg_regs.sv
sv/clcf_ctrl.sv
sv/clcf_out_reg.sv
sv/camera_link_control_fsm.sv
sim/tb.sv
